[sv/dtbl_pkg.sv]
package dtbl_pkg;

	localparam int AXIS_POINTS = 8;
	localparam int IDX_W       = $clog2(AXIS_POINTS);
	localparam int GRID_AW     = 2 * IDX_W;
	localparam int CNT_W       = 4;
	localparam int VAL_W       = 32;
	localparam int WIDE_W      = 64;
	localparam int OFS_W       = 34;
	localparam int MAG_A_W     = 63;
	localparam int MAG_B_W     = 33;
	localparam int PROD_W      = 96;
	localparam int MUL_STEPS   = MAG_B_W;
	localparam int MCNT_W      = $clog2(MUL_STEPS);
	localparam int DCNT_W      = $clog2(PROD_W);

	localparam logic [PROD_W-1:0]  QCAP      = PROD_W'(1) << 62;
	localparam logic signed [WIDE_W-1:0] STAGE_LIM = WIDE_W'(1) << 61;

	typedef enum logic [1:0] {
		OP_WR_SLEW = 2'd0,
		OP_WR_LOAD = 2'd1,
		OP_WR_GRID = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	localparam logic CFG_SLEW_USED = 1'b0;
	localparam logic CFG_LOAD_USED = 1'b1;

	// Request to the interpolation unit: a + round(d * qo / den)
	typedef struct packed {
		logic                     start;
		logic signed [WIDE_W-1:0] a;
		logic signed [WIDE_W-1:0] d;
		logic signed [OFS_W-1:0]  qo;
		logic signed [OFS_W-1:0]  den;
	} lerp_req_t;

	typedef struct packed {
		logic                     done;
		logic                     busy;
		logic signed [WIDE_W-1:0] value;
	} lerp_rsp_t;

	function automatic logic [CNT_W-1:0] used_count(input logic [CNT_W-1:0] r);
		logic [CNT_W-1:0] n;
		n = r;
		if (r < CNT_W'(2)) n = CNT_W'(2);
		else if (r > CNT_W'(AXIS_POINTS)) n = CNT_W'(AXIS_POINTS);
		return n;
	endfunction

endpackage

[sv/dtbl_lerp.sv]
module dtbl_lerp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dtbl_pkg::lerp_req_t  req,
	output dtbl_pkg::lerp_rsp_t  rsp
);

	typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_t;

	lstate_t                                  state_q;
	logic                                     neg_q;
	logic signed [dtbl_pkg::WIDE_W-1:0]       a_q;
	logic [dtbl_pkg::PROD_W-1:0]              acc_q;
	logic [dtbl_pkg::PROD_W-1:0]              mcand_q;
	logic [dtbl_pkg::MAG_B_W-1:0]             mplier_q;
	logic [dtbl_pkg::MAG_B_W-1:0]             mc_q;
	logic [dtbl_pkg::MAG_B_W-1:0]             rem_q;
	logic [dtbl_pkg::PROD_W-1:0]              quo_q;
	logic [dtbl_pkg::MCNT_W-1:0]              mcnt_q;
	logic [dtbl_pkg::DCNT_W-1:0]              dcnt_q;
	logic                                     done_q;
	logic signed [dtbl_pkg::WIDE_W-1:0]       value_q;

	logic [dtbl_pkg::WIDE_W-1:0]              abs_d;
	logic [dtbl_pkg::OFS_W-1:0]               abs_qo, abs_den;
	logic [dtbl_pkg::MAG_B_W:0]               trial;
	logic                                     fits;
	logic                                     sat, rnd;
	logic [dtbl_pkg::MAG_A_W-1:0]             qf;
	logic signed [dtbl_pkg::WIDE_W-1:0]       qs;

	always_comb begin
		abs_d   = req.d[dtbl_pkg::WIDE_W-1] ? -req.d : req.d;
		abs_qo  = req.qo[dtbl_pkg::OFS_W-1] ? -req.qo : req.qo;
		abs_den = req.den[dtbl_pkg::OFS_W-1] ? -req.den : req.den;
		trial   = {rem_q, acc_q[dtbl_pkg::PROD_W-1]};
		fits    = trial >= {1'b0, mc_q};
		sat     = quo_q >= dtbl_pkg::QCAP;
		rnd     = {rem_q, 1'b0} >= {1'b0, mc_q};
		qf      = sat ? dtbl_pkg::QCAP[dtbl_pkg::MAG_A_W-1:0]
		              : quo_q[dtbl_pkg::MAG_A_W-1:0] + dtbl_pkg::MAG_A_W'(rnd);
		qs      = neg_q ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (req.start) begin
						a_q <= req.a;
						if (req.den == '0) begin
							value_q <= req.a;
							done_q  <= 1'b1;
						end else begin
							neg_q    <= req.d[dtbl_pkg::WIDE_W-1] ^ req.qo[dtbl_pkg::OFS_W-1]
							            ^ req.den[dtbl_pkg::OFS_W-1];
							acc_q    <= '0;
							mcand_q  <= dtbl_pkg::PROD_W'(abs_d[dtbl_pkg::MAG_A_W-1:0]);
							mplier_q <= abs_qo[dtbl_pkg::MAG_B_W-1:0];
							mc_q     <= abs_den[dtbl_pkg::MAG_B_W-1:0];
							mcnt_q   <= '0;
							state_q  <= L_MUL;
						end
					end
				end
				L_MUL: begin
					// shift-add: one partial product per cycle
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					mcnt_q   <= mcnt_q + 1'b1;
					if (mcnt_q == dtbl_pkg::MCNT_W'(dtbl_pkg::MUL_STEPS - 1)) begin
						rem_q   <= '0;
						quo_q   <= '0;
						dcnt_q  <= '0;
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					// restoring division, one quotient bit per cycle
					rem_q  <= fits ? dtbl_pkg::MAG_B_W'(trial - {1'b0, mc_q})
					               : trial[dtbl_pkg::MAG_B_W-1:0];
					quo_q  <= {quo_q[dtbl_pkg::PROD_W-2:0], fits};
					acc_q  <= acc_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == dtbl_pkg::DCNT_W'(dtbl_pkg::PROD_W - 1)) state_q <= L_FIN;
				end
				L_FIN: begin
					value_q <= a_q + qs;
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.busy  = state_q != L_IDLE;
	assign rsp.value = value_q;

endmodule

[sv/delay_table_bilinear_lookup.sv]
// Sequence: a write item is taken only while idle and goes straight into its table. A
// query reads and compares each breakpoint visited in each axis search (up to 16
// visits), then reads the bracket ends and grid corners, then for an inexact query makes
// three passes of the shared interpolation unit (shift-add multiply, restoring divide),
// then loads the output register. One query at a time: no item is taken until it is loaded.
// Reset: arst_n clears the sequencer and the output valid; point counts go to 8.
module delay_table_bilinear_lookup (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: slew_index[2:0], load_index[5:3], write_value[37:6],
	//          query_slew[69:38], query_load[101:70], zero pad [103:102]
	input  logic [103:0] s_tdata,
	// s_tuser: op[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tvalid,
	output logic         s_tready,
	// m_tdata: result_value[31:0]
	output logic [31:0]  m_tdata,
	// m_tuser: was_interpolated[0], out_of_range[1]
	output logic [1:0]   m_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [3:0]   cfg_data
);

	localparam int IW = dtbl_pkg::IDX_W;
	localparam int CW = dtbl_pkg::CNT_W;
	localparam int VW = dtbl_pkg::VAL_W;
	localparam int WW = dtbl_pkg::WIDE_W;
	localparam int OW = dtbl_pkg::OFS_W;
	localparam logic signed [WW-1:0] STAGE_LIM_P = dtbl_pkg::STAGE_LIM;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SRD, ST_SCMP, ST_FETCH, ST_LSTART, ST_LWAIT, ST_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      slew_used_q, load_used_q;
	logic [CW-1:0]      ns_q, nl_q;
	logic signed [VW-1:0] qs_q, ql_q;
	logic               axis_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      sl_q, sh_q, ll_q, lh_q;
	logic               se_q, le_q, so_q, lo_oor_q;
	logic [2:0]         fk_q;
	logic [1:0]         pass_q;
	logic signed [VW-1:0] x1_q, x2_q, y1_q, y2_q;
	logic signed [VW-1:0] g00_q, g10_q, g01_q, g11_q;
	logic signed [WW-1:0] rlo_q, rhi_q;
	logic signed [VW-1:0] res_q;
	logic               interp_q;
	logic [31:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;
	logic               m_tvalid_q;

	// Table memories
	logic signed [VW-1:0] bps_mem [dtbl_pkg::AXIS_POINTS];
	logic signed [VW-1:0] bpl_mem [dtbl_pkg::AXIS_POINTS];
	logic signed [VW-1:0] grid_mem [dtbl_pkg::AXIS_POINTS * dtbl_pkg::AXIS_POINTS];
	logic signed [VW-1:0] rd_s_q, rd_l_q, rd_g_q;
	logic [IW-1:0]      addr_s, addr_l;
	logic [dtbl_pkg::GRID_AW-1:0] addr_g;

	// Input fields
	dtbl_pkg::op_t      in_op;
	logic [IW-1:0]      in_si, in_li;
	logic signed [VW-1:0] in_wv, in_qs, in_ql;
	logic               accept;

	dtbl_pkg::lerp_req_t req;
	dtbl_pkg::lerp_rsp_t rsp;

	// Search compare
	logic signed [VW-1:0] bp_cur, q_cur;
	logic [CW-1:0]      n_cur;
	logic               hit_eq, hit_gt, at_end;
	logic [IW-1:0]      lo_nx, hi_nx;
	logic               exact_nx, oor_nx, finish_axis;

	// Interpolation operands
	logic signed [VW:0]   dg_lo, dg_hi, qo_s, den_s, qo_l, den_l;
	logic signed [WW-1:0] clamped, p_val;
	logic signed [VW-1:0] p_sat;

	assign in_op  = dtbl_pkg::op_t'(s_tuser);
	assign in_si  = s_tdata[2:0];
	assign in_li  = s_tdata[5:3];
	assign in_wv  = s_tdata[37:6];
	assign in_qs  = s_tdata[69:38];
	assign in_ql  = s_tdata[101:70];
	assign s_tready = state_q == ST_IDLE;
	assign accept = s_tvalid && s_tready;

	// Address select: search walks idx, fetch picks bracket ends
	always_comb begin
		addr_s = (state_q == ST_FETCH) ? ((fk_q == 3'd0) ? sl_q : sh_q) : idx_q;
		addr_l = (state_q == ST_FETCH) ? ((fk_q == 3'd0) ? ll_q : lh_q) : idx_q;
		unique case (fk_q[1:0])
			2'd0: addr_g = {sl_q, ll_q};
			2'd1: addr_g = {sh_q, ll_q};
			2'd2: addr_g = {sl_q, lh_q};
			2'd3: addr_g = {sh_q, lh_q};
			default: addr_g = {sl_q, ll_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_op == dtbl_pkg::OP_WR_SLEW) bps_mem[in_si] <= in_wv;
		rd_s_q <= bps_mem[addr_s];
	end

	always_ff @(posedge clk) begin
		if (accept && in_op == dtbl_pkg::OP_WR_LOAD) bpl_mem[in_li] <= in_wv;
		rd_l_q <= bpl_mem[addr_l];
	end

	always_ff @(posedge clk) begin
		if (accept && in_op == dtbl_pkg::OP_WR_GRID) grid_mem[{in_si, in_li}] <= in_wv;
		rd_g_q <= grid_mem[addr_g];
	end

	// One search step: exact hit, first greater breakpoint, or run off the end
	always_comb begin
		bp_cur   = axis_q ? rd_l_q : rd_s_q;
		q_cur    = axis_q ? ql_q : qs_q;
		n_cur    = axis_q ? nl_q : ns_q;
		hit_eq   = bp_cur == q_cur;
		hit_gt   = bp_cur > q_cur;
		at_end   = {1'b0, idx_q} == n_cur - 1'b1;
		finish_axis = hit_eq || hit_gt || at_end;
		exact_nx = 1'b0;
		oor_nx   = 1'b0;
		lo_nx    = idx_q;
		hi_nx    = idx_q;
		if (hit_eq) begin
			exact_nx = 1'b1;
		end else if (hit_gt) begin
			if (idx_q == '0) begin
				hi_nx  = IW'(1);
				oor_nx = 1'b1;
			end else begin
				lo_nx = idx_q - 1'b1;
			end
		end else begin
			lo_nx  = IW'(n_cur - CW'(2));
			hi_nx  = IW'(n_cur - CW'(1));
			oor_nx = 1'b1;
		end
	end

	// Operands of the three interpolation passes
	always_comb begin
		dg_lo = {g10_q[VW-1], g10_q} - {g00_q[VW-1], g00_q};
		dg_hi = {g11_q[VW-1], g11_q} - {g01_q[VW-1], g01_q};
		qo_s  = {qs_q[VW-1], qs_q} - {x1_q[VW-1], x1_q};
		den_s = {x2_q[VW-1], x2_q} - {x1_q[VW-1], x1_q};
		qo_l  = {ql_q[VW-1], ql_q} - {y1_q[VW-1], y1_q};
		den_l = {y2_q[VW-1], y2_q} - {y1_q[VW-1], y1_q};
		req.start = state_q == ST_LSTART;
		unique case (pass_q)
			2'd0: begin
				req.a   = WW'(g00_q);
				req.d   = WW'(dg_lo);
				req.qo  = OW'(qo_s);
				req.den = OW'(den_s);
			end
			2'd1: begin
				req.a   = WW'(g01_q);
				req.d   = WW'(dg_hi);
				req.qo  = OW'(qo_s);
				req.den = OW'(den_s);
			end
			default: begin
				req.a   = rlo_q;
				req.d   = rhi_q - rlo_q;
				req.qo  = OW'(qo_l);
				req.den = OW'(den_l);
			end
		endcase
		p_val = rsp.value;
		if (p_val > STAGE_LIM_P) clamped = STAGE_LIM_P;
		else if (p_val < -STAGE_LIM_P) clamped = -STAGE_LIM_P;
		else clamped = p_val;
		if (p_val > WW'(32'sh7FFF_FFFF)) p_sat = 32'sh7FFF_FFFF;
		else if (p_val < -(WW'(64'sh8000_0000))) p_sat = 32'sh8000_0000;
		else p_sat = p_val[VW-1:0];
	end

	dtbl_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slew_used_q <= CW'(dtbl_pkg::AXIS_POINTS);
			load_used_q <= CW'(dtbl_pkg::AXIS_POINTS);
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dtbl_pkg::CFG_SLEW_USED: slew_used_q <= cfg_data;
					dtbl_pkg::CFG_LOAD_USED: load_used_q <= cfg_data;
					default: ;
				endcase
			end
			// drop the result once the downstream transfer completes
			if (m_tvalid_q && m_tready && state_q != ST_DONE) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_op == dtbl_pkg::OP_QUERY) begin
						qs_q    <= in_qs;
						ql_q    <= in_ql;
						ns_q    <= dtbl_pkg::used_count(slew_used_q);
						nl_q    <= dtbl_pkg::used_count(load_used_q);
						axis_q  <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_SRD;
					end
				end
				ST_SRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (finish_axis) begin
						if (!axis_q) begin
							sl_q   <= lo_nx;
							sh_q   <= hi_nx;
							se_q   <= exact_nx;
							so_q   <= oor_nx;
							axis_q <= 1'b1;
							idx_q  <= '0;
							state_q <= ST_SRD;
						end else begin
							ll_q     <= lo_nx;
							lh_q     <= hi_nx;
							le_q     <= exact_nx;
							lo_oor_q <= oor_nx;
							fk_q     <= '0;
							state_q  <= ST_FETCH;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_FETCH: begin
					// capture the read issued in the previous cycle
					fk_q <= fk_q + 1'b1;
					unique case (fk_q)
						3'd1: begin
							x1_q  <= rd_s_q;
							y1_q  <= rd_l_q;
							g00_q <= rd_g_q;
						end
						3'd2: begin
							x2_q  <= rd_s_q;
							y2_q  <= rd_l_q;
							g10_q <= rd_g_q;
						end
						3'd3: g01_q <= rd_g_q;
						3'd4: begin
							g11_q <= rd_g_q;
							if (se_q && le_q) begin
								res_q    <= g00_q;
								interp_q <= 1'b0;
								state_q  <= ST_DONE;
							end else begin
								pass_q  <= 2'd0;
								state_q <= ST_LSTART;
							end
						end
						default: ;
					endcase
				end
				ST_LSTART: state_q <= ST_LWAIT;
				ST_LWAIT: begin
					if (rsp.done) begin
						unique case (pass_q)
							2'd0: begin
								rlo_q   <= clamped;
								pass_q  <= 2'd1;
								state_q <= ST_LSTART;
							end
							2'd1: begin
								rhi_q   <= clamped;
								pass_q  <= 2'd2;
								state_q <= ST_LSTART;
							end
							default: begin
								res_q    <= p_sat;
								interp_q <= 1'b1;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						m_tuser_q  <= {so_q || lo_oor_q, interp_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tvalid = m_tvalid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_LWAIT)
		else $error("interpolation result outside wait state");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCMP |-> {1'b0, idx_q} < n_cur)
		else $error("search index beyond points in use");

	a_unit_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rsp.busy)
		else $error("input ready while interpolation busy");

endmodule

[test/tb.sv]
module tb;

	localparam int NPTS = 8;
	localparam logic [127:0] STEP_CAP = 128'(1) << 62;
	localparam longint STAGE_CLAMP = longint'(1) << 61;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 30;

	logic         clk;
	logic         arst_n;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic         cfg_we;
	logic         cfg_index;
	logic [3:0]   cfg_data;

	delay_table_bilinear_lookup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// one expected lookup answer
	typedef struct {
		logic [31:0] value;
		logic        interp;
		logic        oor;
	} lookup_t;

	lookup_t pending_lookups[$];

	// shadow copy of the table and point counts
	longint   slew_bp[NPTS];
	longint   load_bp[NPTS];
	longint   grid[NPTS*NPTS];
	logic [3:0] slew_cnt_reg;
	logic [3:0] load_cnt_reg;

	int  mismatches;
	int  no_idle;
	int  idle_cycles;
	int  stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic int eff_count(logic [3:0] r);
		if (r < 2) return 2;
		if (r > NPTS) return NPTS;
		return int'(r);
	endfunction

	// round(a*b/c), half away from zero, magnitude capped at 2^62
	function automatic longint scaled_quotient(longint a, longint b, longint c);
		logic neg;
		logic [127:0] ma, mb, mc, prod, quo, rem;
		neg = (a < 0) ^ (b < 0) ^ (c < 0);
		ma = 128'(a < 0 ? -a : a);
		mb = 128'(b < 0 ? -b : b);
		mc = 128'(c < 0 ? -c : c);
		prod = ma * mb;
		quo = prod / mc;
		rem = prod % mc;
		if (quo >= STEP_CAP) quo = STEP_CAP;
		else if (rem >= mc - rem) quo = quo + 1;
		if (quo > STEP_CAP) quo = STEP_CAP;
		return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
	endfunction

	function automatic longint axis_lerp(longint a, longint b, longint q, longint x1,
			longint x2);
		if (x2 == x1) return a;
		return a + scaled_quotient(b - a, q - x1, x2 - x1);
	endfunction

	function automatic longint clamp_stage(longint x);
		if (x > STAGE_CLAMP) return STAGE_CLAMP;
		if (x < -STAGE_CLAMP) return -STAGE_CLAMP;
		return x;
	endfunction

	// scan from position 0; first greater breakpoint ends the bracket
	task automatic bracket(input longint bp[NPTS], input int n, input longint q,
			output int lo, output int hi, output logic hit, output logic outside);
		int i;
		hit = 1'b0;
		outside = 1'b0;
		for (i = 0; i < n; i++) begin
			if (bp[i] == q) begin
				lo = i;
				hi = i;
				hit = 1'b1;
				return;
			end
			if (bp[i] > q) break;
		end
		if (i == 0) begin
			lo = 0;
			hi = 1;
			outside = 1'b1;
		end else if (i == n) begin
			lo = n - 2;
			hi = n - 1;
			outside = 1'b1;
		end else begin
			lo = i - 1;
			hi = i;
		end
	endtask

	task automatic predict_lookup(input logic [31:0] qs_raw, input logic [31:0] ql_raw);
		longint qs, ql, r_lo, r_hi, p;
		int sl, sh, ll, lh;
		logic se, so, le, lo_out;
		lookup_t e;
		qs = longint'($signed(qs_raw));
		ql = longint'($signed(ql_raw));
		bracket(slew_bp, eff_count(slew_cnt_reg), qs, sl, sh, se, so);
		bracket(load_bp, eff_count(load_cnt_reg), ql, ll, lh, le, lo_out);
		if (se && le) begin
			p = grid[sl*NPTS + ll];
		end else begin
			r_lo = clamp_stage(axis_lerp(grid[sl*NPTS + ll], grid[sh*NPTS + ll], qs,
				slew_bp[sl], slew_bp[sh]));
			r_hi = clamp_stage(axis_lerp(grid[sl*NPTS + lh], grid[sh*NPTS + lh], qs,
				slew_bp[sl], slew_bp[sh]));
			p = axis_lerp(r_lo, r_hi, ql, load_bp[ll], load_bp[lh]);
			if (p > VMAX) p = VMAX;
			if (p < VMIN) p = VMIN;
		end
		e.value = p[31:0];
		e.interp = !(se && le);
		e.oor = so || lo_out;
		pending_lookups = {pending_lookups, e};
	endtask

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic int draw_gap();
		if (no_idle != 0) return 0;
		return $urandom_range(0, 10);
	endfunction

	// drive one item and hold it until the transfer; keep tvalid high when the
	// next item follows back to back
	task automatic send_item(input dtbl_pkg::op_t op, input int si, input int li,
			input logic [31:0] wv, input logic [31:0] qs, input logic [31:0] ql);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {2'b00, ql, qs, wv, 3'(li), 3'(si)};
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (op)
			dtbl_pkg::OP_WR_SLEW: slew_bp[si] = longint'($signed(wv));
			dtbl_pkg::OP_WR_LOAD: load_bp[li] = longint'($signed(wv));
			dtbl_pkg::OP_WR_GRID: grid[si*NPTS + li] = longint'($signed(wv));
			dtbl_pkg::OP_QUERY:   predict_lookup(qs, ql);
		endcase
	endtask

	task automatic write_slew(input int i, input longint v);
		send_item(dtbl_pkg::OP_WR_SLEW, i, $urandom_range(0, 7), v[31:0], $urandom,
			$urandom);
	endtask

	task automatic write_load(input int i, input longint v);
		send_item(dtbl_pkg::OP_WR_LOAD, $urandom_range(0, 7), i, v[31:0], $urandom,
			$urandom);
	endtask

	task automatic write_grid(input int s, input int l, input longint v);
		send_item(dtbl_pkg::OP_WR_GRID, s, l, v[31:0], $urandom, $urandom);
	endtask

	task automatic query(input longint qs, input longint ql);
		send_item(dtbl_pkg::OP_QUERY, $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
			qs[31:0], ql[31:0]);
	endtask

	// drop tvalid, let every expected answer arrive, then let trailing writes settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic idx, input logic [3:0] val);
		wait_idle();
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == dtbl_pkg::CFG_SLEW_USED) slew_cnt_reg = val;
		else load_cnt_reg = val;
	endtask

	function automatic longint clamp32(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// coordinate aimed at one region of an axis
	function automatic longint pick_coord(longint bp[NPTS], int n);
		int i;
		longint d;
		i = $urandom_range(0, n - 1);
		case ($urandom_range(0, 6))
			0, 1: return bp[i];
			2, 3: begin
				if (i == n - 1) i = n - 2;
				d = bp[i+1] - bp[i];
				if (d <= 1) return bp[i];
				return bp[i] + 1 + longint'($urandom) % (d - 1);
			end
			4: return clamp32(bp[0] - 1 - longint'($urandom_range(0, 1 << 20)));
			5: return clamp32(bp[n-1] + 1 + longint'($urandom_range(0, 1 << 20)));
			default: begin
				if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) ? VMAX : VMIN);
				return longint'($signed($urandom));
			end
		endcase
	endfunction

	// strictly increasing breakpoints, spacing drawn from one of a few scales
	task automatic load_axis(input logic is_slew);
		longint cur, scale;
		scale = longint'(1) << (4 * $urandom_range(1, 6) + 3);
		cur = -(scale * 4) + longint'($urandom_range(0, 1000));
		for (int i = 0; i < NPTS; i++) begin
			if (is_slew) write_slew(i, cur);
			else write_load(i, cur);
			cur = cur + 1 + longint'($urandom) % scale;
		end
	endtask

	task automatic load_grid();
		longint v;
		for (int s = 0; s < NPTS; s++)
			for (int l = 0; l < NPTS; l++) begin
				if ($urandom_range(0, 9) == 0) v = longint'($signed($urandom));
				else v = longint'($urandom_range(0, 1 << 22)) - (1 << 20);
				write_grid(s, l, v);
			end
	endtask

	task automatic random_queries(input int count);
		for (int k = 0; k < count; k++)
			query(pick_coord(slew_bp, eff_count(slew_cnt_reg)),
				pick_coord(load_bp, eff_count(load_cnt_reg)));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// two-point axes (counts below the minimum), extreme coordinates and values
	task automatic test_corner_cases();
		set_point_count(dtbl_pkg::CFG_SLEW_USED, 4'd0);
		set_point_count(dtbl_pkg::CFG_LOAD_USED, 4'd1);
		write_slew(0, VMIN);
		write_slew(1, VMAX);
		write_load(0, -64'sd65536);
		write_load(1, 64'sd65536);
		write_grid(0, 0, VMAX);
		write_grid(0, 1, VMIN);
		write_grid(1, 0, 64'sd0);
		write_grid(1, 1, -64'sd1);
		query(VMIN, -64'sd65536);      // exact corner
		query(VMAX, 64'sd65536);       // exact corner
		query(VMIN, 64'sd0);           // exact slew, inexact load
		query(64'sd12345, 64'sd65536); // inexact slew, exact load
		query(64'sd0, 64'sd0);         // interior
		query(VMAX, VMAX);             // load above axis
		query(VMIN, VMIN);             // load below axis
		query(64'sd1, 64'sd70000);
		write_slew(0, -64'sd1000);
		write_slew(1, 64'sd1000);
		query(VMIN, VMAX);             // both axes outside, large swing
		query(VMAX, 64'sd3);
		query(-64'sd1000, 64'sd65536);
		query(64'sd999, -64'sd65535);
	endtask

	// well-formed tables with random content under several point counts
	task automatic test_random_tables();
		logic [3:0] sc, lc;
		for (int ph = 0; ph < 5; ph++) begin
			no_idle = (ph == 2);
			load_axis(1'b1);
			load_axis(1'b0);
			load_grid();
			case (ph)
				0: begin sc = 4'd8;  lc = 4'd2;  end
				1: begin sc = 4'd15; lc = 4'd8;  end
				default: begin
					sc = 4'($urandom_range(2, 8));
					lc = 4'($urandom_range(2, 8));
				end
			endcase
			set_point_count(dtbl_pkg::CFG_SLEW_USED, sc);
			set_point_count(dtbl_pkg::CFG_LOAD_USED, lc);
			random_queries(35);
		end
		no_idle = 0;
	endtask

	// repeated and unordered breakpoints, mixed with stray rewrites
	task automatic test_unordered_axes();
		set_point_count(dtbl_pkg::CFG_SLEW_USED, 4'd8);
		set_point_count(dtbl_pkg::CFG_LOAD_USED, 4'd8);
		for (int i = 0; i < NPTS; i++) begin
			write_slew(i, longint'($urandom_range(0, 6)) << 14);
			write_load(i, longint'($signed($urandom)) >>> $urandom_range(0, 24));
		end
		for (int k = 0; k < 60; k++) begin
			case ($urandom_range(0, 7))
				0: write_grid($urandom_range(0, 7), $urandom_range(0, 7),
					longint'($signed($urandom)));
				1: write_slew($urandom_range(0, 7), longint'($urandom_range(0, 6)) << 14);
				default: random_queries(1);
			endcase
		end
	endtask

	// ---------------------------------------------------------------
	// Receive side: stall draws, result checking, watchdog
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			stall_left = draw_gap();
			if (stall_left > 0) m_tready <= 1'b0;
		end else if (!m_tready) begin
			if (stall_left <= 1) m_tready <= 1'b1;
			else stall_left = stall_left - 1;
		end
	end

	always @(posedge clk) begin
		lookup_t e;
		if (m_tvalid && m_tready) begin
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h flags=%b", m_tdata, m_tuser);
			end else begin
				e = pending_lookups.pop_front();
				if (m_tdata !== e.value || m_tuser[0] !== e.interp || m_tuser[1] !== e.oor)
				begin
					mismatches++;
					if (mismatches <= 10)
						$display("lookup: exp value=%h interp=%b oor=%b, got value=%h interp=%b oor=%b",
							e.value, e.interp, e.oor, m_tdata, m_tuser[0], m_tuser[1]);
				end
			end
		end
	end

	// count cycles with no transfer on any port
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("delay_table_bilinear_lookup: mismatch");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		no_idle = 0;
		idle_cycles = 0;
		stall_left = 0;
		slew_cnt_reg = 4'd8;
		load_cnt_reg = 4'd8;
		for (int i = 0; i < NPTS; i++) begin
			slew_bp[i] = 0;
			load_bp[i] = 0;
		end
		for (int i = 0; i < NPTS*NPTS; i++) grid[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_tables();
		test_unordered_axes();

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("delay_table_bilinear_lookup: match");
		else
			$display("delay_table_bilinear_lookup: mismatch");
		$finish;
	end

endmodule
